/* rtl/slt_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// slt_pkg: shared types and constants for the sorted list table
// Request and result structures, opcodes, controller states and commands.
// ----------------------------------------------------------------------------
package slt_pkg;

	localparam int DEPTH_DEF      = 16;
	localparam int ITEM_WIDTH_DEF = 32;
	localparam int OPCODE_W       = 3;
	localparam int VALUE_W        = 32;
	localparam int COUNT_W        = 5;

	typedef enum logic [OPCODE_W-1:0] {
		OP_INSERT   = 3'd0,
		OP_DELETE   = 3'd1,
		OP_LOOKUP   = 3'd2,
		OP_ITER_RST = 3'd3,
		OP_NEXT     = 3'd4,
		OP_CLEAR    = 3'd5
	} opcode_t;

	typedef struct packed {
		logic [OPCODE_W-1:0] opcode;
		logic [VALUE_W-1:0]  item_value;
	} req_item_t;

	typedef struct packed {
		logic               success;
		logic [VALUE_W-1:0] item_out;
		logic               end_of_list;
		logic [COUNT_W-1:0] entry_count;
	} rsp_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_UPD,
		ST_DONE
	} ctl_state_t;

	typedef struct packed {
		logic load;
		logic eval;
		logic apply;
	} slt_cmd_t;

endpackage
`default_nettype wire

/* rtl/sorted_list_table.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_list_table: ordered table with insert, delete, lookup and iterator
// Keeps up to DEPTH items in ascending order in a row of compare-and-shift
// cells driven by a small sequencer.
//
//   Channel   Direction  Handshake             Payload
//   request   in         req_valid/req_stall   slt_pkg::req_item_t
//   result    out        rsp_valid/rsp_stall   slt_pkg::rsp_item_t
//
// A request steps through accept, compare in all cells, then update.
// The result is presented from the cycle after the update, and the next
// request may enter in the cycle the result is taken, not before it.
// Reset leaves the table empty and the iterator before the head.
// A stalled result holds, and further requests are stalled meanwhile.
// ----------------------------------------------------------------------------
module sorted_list_table #(
	parameter int DEPTH      = slt_pkg::DEPTH_DEF,
	parameter int ITEM_WIDTH = slt_pkg::ITEM_WIDTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output      logic               req_stall,
	input  wire slt_pkg::req_item_t req_data,
	output      logic               rsp_valid,
	input  wire logic               rsp_stall,
	output      slt_pkg::rsp_item_t rsp_data
);
	import slt_pkg::*;

	slt_cmd_t cmd;

	slt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd)
	);

	slt_datapath #(
		.DEPTH      (DEPTH),
		.ITEM_WIDTH (ITEM_WIDTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.req_data (req_data),
		.rsp_data (rsp_data)
	);

endmodule
`default_nettype wire

/* rtl/slt_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// slt_ctrl: sequencer for the sorted list table
// Steps each request through compare, update and result hand-off.
// ----------------------------------------------------------------------------
module slt_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	output      logic             req_stall,
	output      logic             rsp_valid,
	input  wire logic             rsp_stall,
	output      slt_pkg::slt_cmd_t cmd
);
	import slt_pkg::*;

	ctl_state_t state_q;
	ctl_state_t state_nxt;
	logic       accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		req_stall = 1'b1;
		rsp_valid = 1'b0;
		accept    = 1'b0;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				accept    = req_valid;
				if (accept) begin
					state_nxt = ST_CMP;
				end
			end
			ST_CMP: begin
				cmd.eval  = 1'b1;
				state_nxt = ST_UPD;
			end
			ST_UPD: begin
				cmd.apply = 1'b1;
				state_nxt = ST_DONE;
			end
			ST_DONE: begin
				rsp_valid = 1'b1;
				// A new request may enter in the same cycle the result leaves.
				req_stall = rsp_stall;
				accept    = req_valid && !rsp_stall;
				if (!rsp_stall) begin
					state_nxt = accept ? ST_CMP : ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
		cmd.load = accept;
	end

endmodule
`default_nettype wire

/* rtl/slt_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// slt_datapath: row of compare-and-shift cells with iterator and count
// Each cell compares its entry with the request item, then shifts in place.
// ----------------------------------------------------------------------------
module slt_datapath #(
	parameter int DEPTH      = slt_pkg::DEPTH_DEF,
	parameter int ITEM_WIDTH = slt_pkg::ITEM_WIDTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire slt_pkg::slt_cmd_t cmd,
	input  wire slt_pkg::req_item_t req_data,
	output      slt_pkg::rsp_item_t rsp_data
);
	import slt_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = $clog2(DEPTH);

	logic [ITEM_WIDTH-1:0]         ent_q [DEPTH];
	logic [ITEM_WIDTH-1:0]         ent_nxt [DEPTH];
	logic [CNT_W-1:0]              count_q;
	logic                          iter_valid_q;
	logic [IDX_W-1:0]              iter_idx_q;
	logic [OPCODE_W-1:0]           op_q;
	logic [ITEM_WIDTH-1:0]         item_q;
	logic [DEPTH-1:0]              lt_s1;
	logic [DEPTH-1:0]              eq_s1;
	logic [CNT_W-1:0]              pos_s1;
	logic                          rd_s1;
	logic                          success_q;
	logic [ITEM_WIDTH-1:0]         res_item_q;
	logic                          eol_q;

	logic [ITEM_WIDTH+VALUE_W-1:0] in_ext;
	logic [ITEM_WIDTH+VALUE_W-1:0] out_ext;
	logic [CNT_W+COUNT_W-1:0]      cnt_ext;
	logic [CNT_W-1:0]              pos_nxt;
	logic                          found;
	logic                          ins_ok;
	logic                          do_ins;
	logic                          do_del;

	assign in_ext  = {{ITEM_WIDTH{1'b0}}, req_data.item_value};
	assign out_ext = {{VALUE_W{1'b0}}, res_item_q};
	assign cnt_ext = {{COUNT_W{1'b0}}, count_q};

	assign pos_nxt = iter_valid_q ? (CNT_W'(iter_idx_q) + CNT_W'(1)) : '0;
	assign found   = |eq_s1;
	assign ins_ok  = count_q < CNT_W'(DEPTH);
	assign do_ins  = (op_q == OP_INSERT) && ins_ok;
	assign do_del  = (op_q == OP_DELETE) && found;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= req_data.opcode;
			item_q <= in_ext[ITEM_WIDTH-1:0];
		end
	end

	// Compare stage: every cell judges its own entry against the item.
	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			for (int i = 0; i < DEPTH; i++) begin
				lt_s1[i] <= (CNT_W'(i) < count_q) && (ent_q[i] < item_q);
				eq_s1[i] <= (CNT_W'(i) < count_q) && (ent_q[i] == item_q);
			end
			pos_s1 <= pos_nxt;
			rd_s1  <= pos_nxt < count_q;
		end
	end

	// Entries are sorted, so the less-than flags form a prefix; on insert the cell where
	// the prefix ends takes the new item and the cells above it shift up, on delete they shift down.
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			ent_nxt[i] = ent_q[i];
		end
		if (do_ins) begin
			if (!lt_s1[0]) begin
				ent_nxt[0] = item_q;
			end
			for (int i = 1; i < DEPTH; i++) begin
				if (!lt_s1[i]) begin
					ent_nxt[i] = lt_s1[i-1] ? item_q : ent_q[i-1];
				end
			end
		end else if (do_del) begin
			for (int i = 0; i < DEPTH - 1; i++) begin
				if (!lt_s1[i]) begin
					ent_nxt[i] = ent_q[i+1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			for (int i = 0; i < DEPTH; i++) begin
				ent_q[i] <= ent_nxt[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			iter_valid_q <= 1'b0;
			iter_idx_q   <= '0;
		end else if (cmd.apply) begin
			case (opcode_t'(op_q))
				OP_INSERT: begin
					if (ins_ok) begin
						count_q <= count_q + CNT_W'(1);
					end
				end
				OP_DELETE: begin
					if (found) begin
						count_q <= count_q - CNT_W'(1);
					end
				end
				OP_ITER_RST: begin
					iter_valid_q <= 1'b0;
					iter_idx_q   <= '0;
				end
				OP_NEXT: begin
					iter_valid_q <= rd_s1;
					iter_idx_q   <= rd_s1 ? pos_s1[IDX_W-1:0] : '0;
				end
				OP_CLEAR: begin
					count_q      <= '0;
					iter_valid_q <= 1'b0;
					iter_idx_q   <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			success_q  <= 1'b0;
			res_item_q <= item_q;
			eol_q      <= 1'b0;
			case (opcode_t'(op_q))
				OP_INSERT: begin
					success_q <= ins_ok;
				end
				OP_DELETE, OP_LOOKUP: begin
					success_q <= found;
				end
				OP_ITER_RST, OP_CLEAR: begin
					success_q <= 1'b1;
				end
				OP_NEXT: begin
					success_q  <= rd_s1;
					eol_q      <= !rd_s1;
					res_item_q <= rd_s1 ? ent_q[pos_s1[IDX_W-1:0]] : '0;
				end
				default: begin
				end
			endcase
		end
	end

	// The count changes only in the update step, so it is still current here.
	always_comb begin
		rsp_data.success     = success_q;
		rsp_data.item_out    = out_ext[VALUE_W-1:0];
		rsp_data.end_of_list = eol_q;
		rsp_data.entry_count = cnt_ext[COUNT_W-1:0];
	end

endmodule
`default_nettype wire
